[rtl/gtfw_pkg.sv]
// Shared types, constants and the 5x7 font ROM of the glyph text framebuffer writer.
// Depends on nothing; every other file of the block imports it.
package gtfw_pkg;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  localparam int          FB_AW         = 10;
  localparam int          FRAME_BYTES   = 1024;
  localparam logic [9:0]  FB_LAST       = 10'h3FF;
  localparam logic [7:0]  FIRST_CODE    = 8'd32;
  localparam logic [7:0]  LAST_CODE     = 8'd126;
  localparam logic [7:0]  FALLBACK_CODE = 8'd63;
  localparam logic [7:0]  ROW_MASK      = 8'h7F;
  localparam int          QUEUE_DEPTH   = 2;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    op_t         op;
    logic        color;
    logic [39:0] glyph;     // five font columns, column 0 in the top byte
    logic [7:0]  x;         // cursor where the glyph is drawn
    logic [7:0]  y;
    logic [9:0]  rd_idx;
    logic [7:0]  col_now;   // cursor after the item
    logic [7:0]  row_now;
  } cmd_t;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_SETUP,
    B_DRAW,
    B_DRAIN,
    B_CLEAR,
    B_READ,
    B_RESULT
  } back_state_t;

  // Font ROM: one 40-bit word per printable code, slot 0 is the space.
  function automatic logic [39:0] font_glyph(input logic [6:0] slot);
    logic [39:0] g;
    unique case (slot)
      7'd0:  g = 40'h00_00_00_00_00;
      7'd1:  g = 40'h00_00_5F_00_00;
      7'd2:  g = 40'h00_07_00_07_00;
      7'd3:  g = 40'h14_7F_14_7F_14;
      7'd4:  g = 40'h24_2A_7F_2A_12;
      7'd5:  g = 40'h23_13_08_64_62;
      7'd6:  g = 40'h36_49_55_22_50;
      7'd7:  g = 40'h00_05_03_00_00;
      7'd8:  g = 40'h00_1C_22_41_00;
      7'd9:  g = 40'h00_41_22_1C_00;
      7'd10: g = 40'h14_08_3E_08_14;
      7'd11: g = 40'h08_08_3E_08_08;
      7'd12: g = 40'h00_50_30_00_00;
      7'd13: g = 40'h08_08_08_08_08;
      7'd14: g = 40'h00_60_60_00_00;
      7'd15: g = 40'h20_10_08_04_02;
      7'd16: g = 40'h3E_51_49_45_3E;
      7'd17: g = 40'h00_42_7F_40_00;
      7'd18: g = 40'h42_61_51_49_46;
      7'd19: g = 40'h21_41_45_4B_31;
      7'd20: g = 40'h18_14_12_7F_10;
      7'd21: g = 40'h27_45_45_45_39;
      7'd22: g = 40'h3C_4A_49_49_30;
      7'd23: g = 40'h01_71_09_05_03;
      7'd24: g = 40'h36_49_49_49_36;
      7'd25: g = 40'h06_49_49_29_1E;
      7'd26: g = 40'h00_36_36_00_00;
      7'd27: g = 40'h00_56_36_00_00;
      7'd28: g = 40'h08_14_22_41_00;
      7'd29: g = 40'h14_14_14_14_14;
      7'd30: g = 40'h00_41_22_14_08;
      7'd31: g = 40'h02_01_51_09_06;
      7'd32: g = 40'h32_49_79_41_3E;
      7'd33: g = 40'h7E_11_11_11_7E;
      7'd34: g = 40'h7F_49_49_49_36;
      7'd35: g = 40'h3E_41_41_41_22;
      7'd36: g = 40'h7F_41_41_22_1C;
      7'd37: g = 40'h7F_49_49_49_41;
      7'd38: g = 40'h7F_09_09_09_01;
      7'd39: g = 40'h3E_41_49_49_7A;
      7'd40: g = 40'h7F_08_08_08_7F;
      7'd41: g = 40'h00_41_7F_41_00;
      7'd42: g = 40'h20_40_41_3F_01;
      7'd43: g = 40'h7F_08_14_22_41;
      7'd44: g = 40'h7F_40_40_40_40;
      7'd45: g = 40'h7F_02_0C_02_7F;
      7'd46: g = 40'h7F_04_08_10_7F;
      7'd47: g = 40'h3E_41_41_41_3E;
      7'd48: g = 40'h7F_09_09_09_06;
      7'd49: g = 40'h3E_41_51_21_5E;
      7'd50: g = 40'h7F_09_19_29_46;
      7'd51: g = 40'h46_49_49_49_31;
      7'd52: g = 40'h01_01_7F_01_01;
      7'd53: g = 40'h3F_40_40_40_3F;
      7'd54: g = 40'h1F_20_40_20_1F;
      7'd55: g = 40'h3F_40_38_40_3F;
      7'd56: g = 40'h63_14_08_14_63;
      7'd57: g = 40'h07_08_70_08_07;
      7'd58: g = 40'h61_51_49_45_43;
      7'd59: g = 40'h00_7F_41_41_00;
      7'd60: g = 40'h02_04_08_10_20;
      7'd61: g = 40'h00_41_41_7F_00;
      7'd62: g = 40'h04_02_01_02_04;
      7'd63: g = 40'h40_40_40_40_40;
      7'd64: g = 40'h00_01_02_04_00;
      7'd65: g = 40'h20_54_54_54_78;
      7'd66: g = 40'h7F_48_44_44_38;
      7'd67: g = 40'h38_44_44_44_20;
      7'd68: g = 40'h38_44_44_48_7F;
      7'd69: g = 40'h38_54_54_54_18;
      7'd70: g = 40'h08_7E_09_01_02;
      7'd71: g = 40'h0C_52_52_52_3E;
      7'd72: g = 40'h7F_08_04_04_78;
      7'd73: g = 40'h00_44_7D_40_00;
      7'd74: g = 40'h20_40_44_3D_00;
      7'd75: g = 40'h7F_10_28_44_00;
      7'd76: g = 40'h00_41_7F_40_00;
      7'd77: g = 40'h7C_04_18_04_78;
      7'd78: g = 40'h7C_08_04_04_78;
      7'd79: g = 40'h38_44_44_44_38;
      7'd80: g = 40'h7C_14_14_14_08;
      7'd81: g = 40'h08_14_14_18_7C;
      7'd82: g = 40'h7C_08_04_04_08;
      7'd83: g = 40'h48_54_54_54_20;
      7'd84: g = 40'h04_3F_44_40_20;
      7'd85: g = 40'h3C_40_40_20_7C;
      7'd86: g = 40'h1C_20_40_20_1C;
      7'd87: g = 40'h3C_40_30_40_3C;
      7'd88: g = 40'h44_28_10_28_44;
      7'd89: g = 40'h0C_50_50_50_3C;
      7'd90: g = 40'h44_64_54_4C_44;
      7'd91: g = 40'h00_08_36_41_00;
      7'd92: g = 40'h00_00_7F_00_00;
      7'd93: g = 40'h00_41_36_08_00;
      7'd94: g = 40'h10_08_08_10_08;
      default: g = 40'h00_00_00_00_00;
    endcase
    return g;
  endfunction

  // Picks one column out of a glyph word; columns past the fifth are unlit.
  function automatic logic [7:0] glyph_col(input logic [39:0] g, input logic [2:0] c);
    logic [7:0] col;
    unique case (c)
      3'd0:    col = g[39:32];
      3'd1:    col = g[31:24];
      3'd2:    col = g[23:16];
      3'd3:    col = g[15:8];
      3'd4:    col = g[7:0];
      default: col = 8'h00;
    endcase
    return col;
  endfunction

endpackage

[rtl/glyph_text_framebuffer_writer.sv]
// Top level of the glyph text framebuffer writer: front end, command queue and back end.
// Depends on gtfw_pkg, gtfw_front, gtfw_queue and gtfw_back.
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+--------------------------------------------
//   in_     | input     | in_valid/in_ready   | func, char_code, color, cursor_col/row,
//           |           |                     | read_index
//   out_    | output    | out_valid/out_ready | read_data, cursor_col_now, cursor_row_now
//
// In the back end a put-character item runs a setup state, then handles one framebuffer
// byte per cycle, read and written back through the single-read, single-write
// framebuffer memory. A clear writes one byte per cycle over the whole framebuffer.
// After reset the framebuffer is swept to zero; in_ready stays low until the sweep is
// done. The two-entry queue lets the input side run ahead of a stalled output.
module glyph_text_framebuffer_writer import gtfw_pkg::*; #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64,
  parameter int GLYPH_WIDTH    = 5,
  parameter int GLYPH_HEIGHT   = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [7:0] in_char_code,
  input  logic       in_color,
  input  logic [7:0] in_cursor_col,
  input  logic [7:0] in_cursor_row,
  input  logic [9:0] in_read_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic [7:0] out_cursor_col_now,
  output logic [7:0] out_cursor_row_now
);

  // Command transfer from the front end into the queue.
  logic q_push;
  logic q_ready;
  cmd_t push_data;

  // Command transfer from the queue into the back end.
  logic q_pop;
  logic q_valid;
  cmd_t pop_data;

  // The back end holds off the front end until the framebuffer sweep after reset is done.
  logic init_done;

  // The front end also owns the text cursor, so each command already carries the
  // cursor values that its result reports.
  gtfw_front #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .GLYPH_WIDTH   (GLYPH_WIDTH),
    .GLYPH_HEIGHT  (GLYPH_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_char_code  (in_char_code),
    .in_color      (in_color),
    .in_cursor_col (in_cursor_col),
    .in_cursor_row (in_cursor_row),
    .in_read_index (in_read_index),
    .init_done     (init_done),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_data        (push_data)
  );

  gtfw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .q_ready   (q_ready),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .pop_data  (pop_data)
  );

  // The back end executes commands strictly in order and registers each result.
  gtfw_back #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
    .GLYPH_WIDTH    (GLYPH_WIDTH),
    .GLYPH_HEIGHT   (GLYPH_HEIGHT)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_data             (pop_data),
    .q_pop              (q_pop),
    .init_done          (init_done),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_cursor_col_now (out_cursor_col_now),
    .out_cursor_row_now (out_cursor_row_now)
  );

endmodule

[rtl/gtfw_front.sv]
// Front end: accepts items, maps the character to a font word and tracks the text cursor.
// Depends on gtfw_pkg for the command type, op codes and the font ROM.
module gtfw_front import gtfw_pkg::*; #(
  parameter int DISPLAY_WIDTH = 128,
  parameter int GLYPH_WIDTH   = 5,
  parameter int GLYPH_HEIGHT  = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [7:0] in_char_code,
  input  logic       in_color,
  input  logic [7:0] in_cursor_col,
  input  logic [7:0] in_cursor_row,
  input  logic [9:0] in_read_index,
  input  logic       init_done,
  input  logic       q_ready,
  output logic       q_push,
  output cmd_t       q_data
);

  localparam logic [7:0] ADV_X   = 8'(GLYPH_WIDTH + 1);
  localparam logic [7:0] ADV_Y   = 8'(GLYPH_HEIGHT + 1);
  localparam logic [8:0] WRAP_AT = 9'(DISPLAY_WIDTH - GLYPH_WIDTH);

  logic [7:0] cur_x_r, cur_x_nxt;
  logic [7:0] cur_y_r, cur_y_nxt;
  logic [7:0] code;
  logic [7:0] adv_x;
  op_t        op;

  assign in_ready = init_done && q_ready;
  assign q_push   = in_valid && in_ready;
  assign op       = op_t'(in_func);

  always_comb begin
    code = ((in_char_code < FIRST_CODE) || (in_char_code > LAST_CODE)) ?
           FALLBACK_CODE : in_char_code;
    adv_x = cur_x_r + ADV_X;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    unique case (op)
      OP_PUT: begin
        if ({1'b0, adv_x} >= WRAP_AT) begin
          cur_x_nxt = 8'd0;
          cur_y_nxt = cur_y_r + ADV_Y;
        end else begin
          cur_x_nxt = adv_x;
        end
      end
      OP_SET: begin
        cur_x_nxt = in_cursor_col;
        cur_y_nxt = in_cursor_row;
      end
      default: begin
        cur_x_nxt = cur_x_r;
        cur_y_nxt = cur_y_r;
      end
    endcase
  end

  always_comb begin
    q_data.op      = op;
    q_data.color   = in_color;
    q_data.glyph   = font_glyph(7'(code - FIRST_CODE));
    q_data.x       = cur_x_r;
    q_data.y       = cur_y_r;
    q_data.rd_idx  = in_read_index;
    q_data.col_now = cur_x_nxt;
    q_data.row_now = cur_y_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= 8'd0;
      cur_y_r <= 8'd0;
    end else if (q_push) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
    end
  end

endmodule

[rtl/gtfw_queue.sv]
// Two-entry command queue between the front end and the framebuffer engine.
// Depends on gtfw_pkg for the command type and depth.
module gtfw_queue import gtfw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic q_ready,
  input  logic pop,
  output logic q_valid,
  output cmd_t pop_data
);

  cmd_t       slot_r [QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r,  count_nxt;

  assign q_ready  = (count_r != 2'(QUEUE_DEPTH));
  assign q_valid  = (count_r != 2'd0);
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/gtfw_back.sv]
// Back end: owns the framebuffer memory, runs glyph read-modify-writes, clears and reads,
// and holds the result register. Depends on gtfw_pkg for types, constants and helpers.
module gtfw_back import gtfw_pkg::*; #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64,
  parameter int GLYPH_WIDTH    = 5,
  parameter int GLYPH_HEIGHT   = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_data,
  output logic       q_pop,
  output logic       init_done,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic [7:0] out_cursor_col_now,
  output logic [7:0] out_cursor_row_now
);

  localparam logic [2:0]  LAST_COL  = 3'(GLYPH_WIDTH - 1);
  localparam logic [7:0]  CELL_BITS = 8'((9'd1 << GLYPH_HEIGHT) - 9'd1);
  localparam logic [8:0]  W9        = 9'(DISPLAY_WIDTH);
  localparam logic [8:0]  H9        = 9'(DISPLAY_HEIGHT);
  localparam logic [12:0] W13       = 13'(DISPLAY_WIDTH);
  localparam logic [12:0] FB_END    = 13'(FRAME_BYTES);

  logic [7:0] mem [FRAME_BYTES];
  logic [7:0] rd_data_r;

  back_state_t state_r, state_nxt;
  cmd_t        cmd_r;
  logic [9:0]  clr_r;
  logic [2:0]  col_r;
  logic        half_r;
  logic [12:0] base_a_r, base_b_r;
  logic [7:0]  mask_a_r, mask_b_r;
  logic        p_valid_r, p_valid_nxt;
  logic [9:0]  p_idx_r;
  logic [7:0]  p_mask_r, p_set_r;
  logic        out_valid_r;
  logic [7:0]  out_data_r, out_col_r, out_row_r;

  // Setup arithmetic.
  logic [4:0]  page_a, page_b;
  logic [15:0] cell16;
  logic [7:0]  vis_a, vis_b;

  // Per-step arithmetic.
  logic [7:0]  px;
  logic [12:0] idx;
  logic [7:0]  mask, line8, set_bits;
  logic [15:0] line16;
  logic        step_ok, last_step;

  // Port and control outputs.
  logic        we;
  logic [9:0]  waddr, raddr;
  logic [7:0]  wdata;
  logic        load_cmd, load_res, step_adv;

  assign init_done          = (state_r != B_INIT);
  assign out_valid          = out_valid_r;
  assign out_read_data      = out_data_r;
  assign out_cursor_col_now = out_col_r;
  assign out_cursor_row_now = out_row_r;

  always_comb begin
    page_a = cmd_r.y[7:3];
    page_b = page_a + 5'd1;
    cell16 = {8'd0, CELL_BITS} << cmd_r.y[2:0];
    for (int b = 0; b < 8; b++) begin
      vis_a[b] = ({1'b0, page_a, 3'(b)} < H9);
      vis_b[b] = ({1'b0, page_b, 3'(b)} < H9);
    end
  end

  always_comb begin
    px        = cmd_r.x + {5'd0, col_r};
    idx       = {5'd0, px} + (half_r ? base_b_r : base_a_r);
    mask      = half_r ? mask_b_r : mask_a_r;
    line8     = glyph_col(cmd_r.glyph, col_r) & ROW_MASK & CELL_BITS;
    line16    = {8'd0, line8} << cmd_r.y[2:0];
    set_bits  = cmd_r.color ? ((half_r ? line16[15:8] : line16[7:0]) & mask) : 8'd0;
    step_ok   = ({1'b0, px} < W9) && (idx < FB_END) && (mask != 8'd0);
    last_step = half_r && (col_r == LAST_COL);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_INIT:   if (clr_r == FB_LAST) state_nxt = B_IDLE;
      B_IDLE: begin
        if (q_valid) begin
          unique case (q_data.op)
            OP_PUT:   state_nxt = B_SETUP;
            OP_SET:   state_nxt = B_RESULT;
            OP_CLEAR: state_nxt = B_CLEAR;
            OP_READ:  state_nxt = B_READ;
            default:  state_nxt = B_RESULT;
          endcase
        end
      end
      B_SETUP:  state_nxt = B_DRAW;
      B_DRAW:   if (last_step) state_nxt = B_DRAIN;
      B_DRAIN:  state_nxt = B_RESULT;
      B_CLEAR:  if (clr_r == FB_LAST) state_nxt = B_RESULT;
      B_READ:   state_nxt = B_RESULT;
      B_RESULT: if (!out_valid_r || out_ready) state_nxt = B_IDLE;
      default:  state_nxt = B_INIT;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    we          = 1'b0;
    waddr       = p_idx_r;
    wdata       = (rd_data_r & ~p_mask_r) | p_set_r;
    raddr       = cmd_r.rd_idx;
    q_pop       = 1'b0;
    load_cmd    = 1'b0;
    load_res    = 1'b0;
    step_adv    = 1'b0;
    p_valid_nxt = 1'b0;
    unique case (state_r)
      B_INIT, B_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = 8'd0;
      end
      B_IDLE: begin
        q_pop    = q_valid;
        load_cmd = q_valid;
      end
      B_DRAW: begin
        // Read this step's byte while the previous step's byte is written back.
        we          = p_valid_r;
        raddr       = idx[9:0];
        step_adv    = 1'b1;
        p_valid_nxt = step_ok;
      end
      B_DRAIN:  we = p_valid_r;
      B_RESULT: load_res = !out_valid_r || out_ready;
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_INIT;
      clr_r       <= 10'd0;
      col_r       <= 3'd0;
      half_r      <= 1'b0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      p_valid_r <= p_valid_nxt;
      if ((state_r == B_INIT) || (state_r == B_CLEAR)) begin
        clr_r <= clr_r + 10'd1;
      end
      if (step_adv) begin
        if (last_step) begin
          col_r  <= 3'd0;
          half_r <= 1'b0;
        end else if (half_r) begin
          col_r  <= col_r + 3'd1;
          half_r <= 1'b0;
        end else begin
          half_r <= 1'b1;
        end
      end
      if (load_res) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_cmd) begin
      cmd_r <= q_data;
    end
    if (state_r == B_SETUP) begin
      base_a_r <= 13'({8'd0, page_a} * W13);
      base_b_r <= 13'({8'd0, page_b} * W13);
      mask_a_r <= cell16[7:0]  & vis_a;
      mask_b_r <= cell16[15:8] & vis_b;
    end
    if (step_adv) begin
      p_idx_r  <= idx[9:0];
      p_mask_r <= mask;
      p_set_r  <= set_bits;
    end
    if (load_res) begin
      out_data_r <= (cmd_r.op == OP_READ) ? rd_data_r : 8'd0;
      out_col_r  <= cmd_r.col_now;
      out_row_r  <= cmd_r.row_now;
    end
  end

endmodule

[test/glyph_text_framebuffer_writer_checker.sv]
`timescale 1ns / 100ps
// Checker for the glyph text framebuffer writer: snoops both channels, predicts each reply.
// Holds its own font table, framebuffer image and cursor; depends on gtfw_pkg for codes.
module glyph_text_framebuffer_checker import gtfw_pkg::*; #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64,
  parameter int GLYPH_WIDTH    = 5,
  parameter int GLYPH_HEIGHT   = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [7:0] in_char_code,
  input  logic       in_color,
  input  logic [7:0] in_cursor_col,
  input  logic [7:0] in_cursor_row,
  input  logic [9:0] in_read_index,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_read_data,
  input  logic [7:0] out_cursor_col_now,
  input  logic [7:0] out_cursor_row_now,
  output int         fail_count,
  output int         pending,
  output int         checked
);

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] col;
    logic [7:0] row;
  } screen_reply_t;

  // Five columns per printable code, column 0 in the top byte, starting at the space.
  logic [39:0] font_words [0:94] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h1008081008
  };

  logic [7:0]    screen_image [0:FRAME_BYTES-1];
  logic [7:0]    text_x;
  logic [7:0]    text_y;
  screen_reply_t pending_replies [$];
  int            failures;
  int            compared;

  function automatic void draw_glyph(input logic [7:0] code_in, input logic white);
    logic [7:0] code;
    logic [7:0] line;
    int         c;
    int         r;
    int         px;
    int         py;
    int         idx;
    code = code_in;
    if (code < FIRST_CODE || code > LAST_CODE) code = FALLBACK_CODE;
    for (c = 0; c < GLYPH_WIDTH; c++) begin
      line = 8'h00;
      if (c < 5) line = font_words[code - FIRST_CODE][39 - 8 * c -: 8] & ROW_MASK;
      px = (int'(text_x) + c) & 255;
      for (r = 0; r < GLYPH_HEIGHT; r++) begin
        py = (int'(text_y) + r) & 255;
        if (px < DISPLAY_WIDTH && py < DISPLAY_HEIGHT) begin
          idx = px + (py >> 3) * DISPLAY_WIDTH;
          if (idx < FRAME_BYTES) begin
            if (white && line[r & 7]) screen_image[idx][py & 7] = 1'b1;
            else                      screen_image[idx][py & 7] = 1'b0;
          end
        end
      end
    end
    text_x = text_x + 8'(GLYPH_WIDTH + 1);
    if (int'(text_x) >= DISPLAY_WIDTH - GLYPH_WIDTH) begin
      text_x = 8'd0;
      text_y = text_y + 8'(GLYPH_HEIGHT + 1);
    end
  endfunction

  // Applies one accepted item to the image and returns the reply it must produce.
  function automatic screen_reply_t predict_reply();
    screen_reply_t rep;
    rep.data = 8'h00;
    case (op_t'(in_func))
      OP_PUT:   draw_glyph(in_char_code, in_color);
      OP_SET: begin
        text_x = in_cursor_col;
        text_y = in_cursor_row;
      end
      OP_CLEAR: foreach (screen_image[i]) screen_image[i] = 8'h00;
      default:  rep.data = screen_image[in_read_index];
    endcase
    rep.col = text_x;
    rep.row = text_y;
    return rep;
  endfunction

  always @(posedge clk) begin
    screen_reply_t want;
    if (!rst_n) begin
      foreach (screen_image[i]) screen_image[i] = 8'h00;
      text_x = 8'd0;
      text_y = 8'd0;
      pending_replies.delete();
      failures = 0;
      compared = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          if (failures < 10)
            $display("[%0t] reply with nothing outstanding: data %h col %0d row %0d", $time,
                     out_read_data, out_cursor_col_now, out_cursor_row_now);
          failures++;
        end else begin
          want = pending_replies.pop_front();
          compared++;
          if (out_read_data !== want.data || out_cursor_col_now !== want.col ||
              out_cursor_row_now !== want.row) begin
            if (failures < 10)
              $display("[%0t] reply mismatch: data %h/%h col %0d/%0d row %0d/%0d (exp/got)",
                       $time, want.data, out_read_data, want.col, out_cursor_col_now,
                       want.row, out_cursor_row_now);
            failures++;
          end
        end
      end
      if (in_valid && in_ready) pending_replies.push_back(predict_reply());
    end
    fail_count <= failures;
    pending    <= pending_replies.size();
    checked    <= compared;
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// Top of the glyph text framebuffer writer regression: clock, reset, stimulus and verdict.
// Depends on gtfw_pkg, the block itself and glyph_text_framebuffer_checker.
module testbench;
  import gtfw_pkg::*;

  // Cycles with no transfer on either channel before the run is declared hung. The slowest
  // honest gap is a clear behind the long output hold-off below.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_ITEMS   = 750;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_func = OP_READ;
  logic [7:0] in_char_code = 8'd0;
  logic       in_color = 1'b0;
  logic [7:0] in_cursor_col = 8'd0;
  logic [7:0] in_cursor_row = 8'd0;
  logic [9:0] in_read_index = 10'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_read_data;
  logic [7:0] out_cursor_col_now;
  logic [7:0] out_cursor_row_now;

  int fail_count;
  int pending;
  int checked;

  // Stimulus-side knobs shared with the receiver process.
  logic quiet_window = 1'b0;   // no idling on either side while set
  logic hold_request = 1'b0;   // asks the receiver for one long hold-off
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   idle_cycles = 0;

  int n_put = 0;
  int n_set = 0;
  int n_clear = 0;
  int n_read = 0;

  glyph_text_framebuffer_writer uut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_func, .in_char_code, .in_color,
    .in_cursor_col, .in_cursor_row, .in_read_index,
    .out_valid, .out_ready, .out_read_data, .out_cursor_col_now, .out_cursor_row_now
  );

  glyph_text_framebuffer_checker screen_check (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_func, .in_char_code, .in_color,
    .in_cursor_col, .in_cursor_row, .in_read_index,
    .out_valid, .out_ready, .out_read_data, .out_cursor_col_now, .out_cursor_row_now,
    .fail_count, .pending, .checked
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver takes replies at random, about 88 times in 100. Once per run it refuses for a long
  // stretch so the two-entry queue fills and in_ready drops while the sender keeps offering.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (quiet_window) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 12);
    end
  end

  // Watchdog: any transfer on either channel restarts the count. This also covers the
  // framebuffer sweep after reset, during which in_ready stays low.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d cycles without a transfer", idle_cycles);
      $display("glyph_text_framebuffer_writer regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one item and returns at the edge where it transfers. A random gap may come
  // first, with in_valid low; otherwise in_valid stays high straight into the next item.
  task automatic send_item(input op_t op, input logic [7:0] code, input logic color,
                           input logic [7:0] col, input logic [7:0] row,
                           input logic [9:0] idx);
    if (!quiet_window && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= op;
    in_char_code  <= code;
    in_color      <= color;
    in_cursor_col <= col;
    in_cursor_row <= row;
    in_read_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (op)
      OP_PUT:   n_put++;
      OP_SET:   n_set++;
      OP_CLEAR: n_clear++;
      default:  n_read++;
    endcase
  endtask

  initial begin
    int         pick;
    logic [7:0] anchor_x;
    logic [7:0] anchor_y;
    logic [7:0] code;
    logic [7:0] set_x;
    logic [7:0] set_y;
    logic [9:0] idx;
    anchor_x = 8'd0;
    anchor_y = 8'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Reads straight after reset see the swept framebuffer at both ends.
    send_item(OP_READ, 8'h00, 1'b0, 8'h00, 8'h00, 10'd0);
    send_item(OP_READ, 8'hFF, 1'b1, 8'hFF, 8'hFF, FB_LAST);
    send_item(OP_SET, 8'h00, 1'b0, 8'd0, 8'd0, 10'd0);
    send_item(OP_PUT, 8'd65, 1'b1, 8'h00, 8'h00, 10'd0);
    send_item(OP_READ, 8'h00, 1'b0, 8'h00, 8'h00, 10'd1);
    // Codes outside the printable range are drawn as the question mark, in either color.
    send_item(OP_PUT, 8'd0, 1'b1, 8'h00, 8'h00, 10'd0);
    send_item(OP_PUT, 8'd255, 1'b1, 8'hFF, 8'hFF, FB_LAST);
    send_item(OP_PUT, LAST_CODE, 1'b1, 8'h00, 8'h00, 10'd0);
    send_item(OP_PUT, FIRST_CODE, 1'b1, 8'h00, 8'h00, 10'd0);
    send_item(OP_PUT, 8'd127, 1'b0, 8'h00, 8'h00, 10'd0);
    send_item(OP_READ, 8'h00, 1'b0, 8'h00, 8'h00, 10'd6);
    // A glyph hanging off the right and bottom edges, then the wrap to the next text row.
    send_item(OP_SET, 8'h00, 1'b0, 8'd125, 8'd60, 10'd0);
    send_item(OP_PUT, 8'd87, 1'b1, 8'h00, 8'h00, 10'd0);
    send_item(OP_READ, 8'h00, 1'b0, 8'h00, 8'h00, 10'd1021);
    // Cursor at the top of the 8-bit range: pixel coordinates wrap back onto the screen.
    send_item(OP_SET, 8'h00, 1'b0, 8'd255, 8'd255, 10'd0);
    send_item(OP_PUT, 8'd35, 1'b1, 8'h00, 8'h00, 10'd0);
    send_item(OP_READ, 8'h00, 1'b0, 8'h00, 8'h00, 10'd0);
    send_item(OP_READ, 8'h00, 1'b0, 8'h00, 8'h00, 10'd1);
    // Black erases the whole cell that was drawn earlier.
    send_item(OP_SET, 8'h00, 1'b0, 8'd0, 8'd0, 10'd0);
    send_item(OP_PUT, 8'd65, 1'b0, 8'h00, 8'h00, 10'd0);
    send_item(OP_READ, 8'h00, 1'b0, 8'h00, 8'h00, 10'd1);
    // Advance landing exactly on the wrap column, and one short of it.
    send_item(OP_SET, 8'h00, 1'b0, 8'd117, 8'd8, 10'd0);
    send_item(OP_PUT, 8'd66, 1'b1, 8'h00, 8'h00, 10'd0);
    send_item(OP_SET, 8'h00, 1'b0, 8'd116, 8'd16, 10'd0);
    send_item(OP_PUT, 8'd66, 1'b1, 8'h00, 8'h00, 10'd0);
    send_item(OP_CLEAR, 8'h00, 1'b0, 8'h00, 8'h00, 10'd0);
    send_item(OP_READ, 8'h00, 1'b0, 8'h00, 8'h00, 10'd1);

    // Random part: mostly text, with half of the reads aimed near the last cursor move so drawn
    // pixels get read back. Fields that an operation ignores carry random noise.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet_window <= (n >= 300 && n < 450);
      if (n == 200) hold_request <= 1'b1;
      pick = $urandom_range(0, 199);
      if ($urandom_range(0, 99) < 85) code = 8'($urandom_range(FIRST_CODE, LAST_CODE));
      else                            code = 8'($urandom_range(0, 255));
      if (pick < 100) begin
        send_item(OP_PUT, code, ($urandom_range(0, 99) < 80), 8'($urandom), 8'($urandom),
                  10'($urandom));
      end else if (pick < 130) begin
        if ($urandom_range(0, 3) != 0) begin
          set_x = 8'($urandom_range(0, 127));
          set_y = 8'($urandom_range(0, 63));
        end else begin
          set_x = 8'($urandom);
          set_y = 8'($urandom);
        end
        anchor_x = set_x;
        anchor_y = set_y;
        send_item(OP_SET, 8'($urandom), 1'($urandom), set_x, set_y, 10'($urandom));
      end else if (pick < 133) begin
        send_item(OP_CLEAR, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                  10'($urandom));
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          idx = 10'($urandom);
        end else begin
          idx[6:0] = 7'(int'(anchor_x) + $urandom_range(0, 23));
          idx[9:7] = 3'(int'(anchor_y >> 3) + $urandom_range(0, 1));
        end
        send_item(OP_READ, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom), idx);
      end
    end
    in_valid     <= 1'b0;
    quiet_window <= 1'b0;

    // Drain: waiting first lets the outstanding count include the last transfer in. The
    // watchdog bounds this wait, then a short tail catches stray replies.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d transfers in (%0d put, %0d set, %0d clear, %0d read), %0d replies checked.",
             n_put + n_set + n_clear + n_read, n_put, n_set, n_clear, n_read, checked);
    $display("Covered fallback glyphs, edge clipping, cursor wrap and a %0d-cycle output stall.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("glyph_text_framebuffer_writer regression: pass");
    end else begin
      $display("%0d failures, %0d replies never arrived", fail_count, pending);
      $display("glyph_text_framebuffer_writer regression: fail");
    end
    $finish;
  end

endmodule
